// ----- hdl/sccb_register_master_macros.svh -----
// Assertion macros shared by the SCCB register master RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef SCCB_REGISTER_MASTER_MACROS_SVH
`define SCCB_REGISTER_MASTER_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property on every rising clock edge outside reset.
`define SCM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sccb_register_master: assertion failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define SCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sccb_register_master: assertion failed");
`else
`define SCM_ASSERT(label, clk, rst, prop)
`define SCM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/scm_pkg.sv -----
// Types, codes and constants of the SCCB register master.
// Used by scm_step, scm_rsp_reg and sccb_register_master; no dependencies.
`default_nettype none

package scm_pkg;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd66;

   // Bus segment; the phase within a segment is kept separately.
   typedef enum logic [3:0] {
      SEG_IDLE      = 4'd0,
      SEG_STARTA    = 4'd1,
      SEG_DEVW      = 4'd2,
      SEG_ACKDEV    = 4'd3,
      SEG_REG       = 4'd4,
      SEG_ACKREG    = 4'd5,
      SEG_DATA      = 4'd6,
      SEG_ACKDATA   = 4'd7,
      SEG_STOPEND   = 4'd8,
      SEG_STOPABORT = 4'd9,
      SEG_STOPMID   = 4'd10,
      SEG_STARTB    = 4'd11,
      SEG_DEVR      = 4'd12,
      SEG_ACKDEVR   = 4'd13,
      SEG_RX        = 4'd14,
      SEG_MACK      = 4'd15
   } seg_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BUS_BUSY   = 2'd1,
      STATUS_LINE_STUCK = 2'd2,
      STATUS_NO_ACK     = 2'd3
   } status_type;

   typedef struct packed {
      seg_type    seg;
      logic [1:0] phase;
      logic [3:0] bit_count;
      logic [7:0] shift_byte;
      logic [7:0] bytes_left;
      logic [7:0] held_reg_addr;
      logic [7:0] held_write_data;
      logic       is_read;
      logic       scl;
      logic       sda;
   } state_type;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      status_type status;
      logic [7:0] read_data;
      logic       read_valid;
      logic       read_last;
   } result_type;

   localparam state_type STATE_RESET = '{
      seg:             SEG_IDLE,
      phase:           2'd0,
      bit_count:       4'd0,
      shift_byte:      8'd0,
      bytes_left:      8'd0,
      held_reg_addr:   8'd0,
      held_write_data: 8'd0,
      is_read:         1'b0,
      scl:             1'b1,
      sda:             1'b1
   };

endpackage

`default_nettype wire

// ----- hdl/scm_step.sv -----
// Combinational bus phase logic: next controller state and result of one item.
// Depends on scm_pkg.
`default_nettype none

module scm_step (
   input  scm_pkg::state_type  cur,
   input  logic [1:0]          operation,
   input  logic [7:0]          reg_addr,
   input  logic [7:0]          write_data,
   input  logic [7:0]          read_length,
   input  logic                sda_in,
   input  logic [7:0]          device_address,
   output scm_pkg::state_type  nxt,
   output scm_pkg::result_type res
);
   import scm_pkg::*;

   logic       is_cmd;
   logic [3:0] bc_inc;
   logic [7:0] rx_shift;
   logic [7:0] bl_dec;

   assign is_cmd   = operation inside {OP_WRITE, OP_READ};
   assign bc_inc   = cur.bit_count + 4'd1;
   assign rx_shift = {cur.shift_byte[6:0], sda_in};
   assign bl_dec   = (cur.bytes_left != 8'd0) ? cur.bytes_left - 8'd1 : cur.bytes_left;

   always_comb begin
      nxt = cur;
      res = '0;
      if (cur.seg == SEG_IDLE) begin
         if (is_cmd) begin
            nxt.held_reg_addr   = reg_addr;
            nxt.held_write_data = write_data;
            nxt.bytes_left      = read_length;
            nxt.is_read         = (operation == OP_READ);
            nxt.seg             = SEG_STARTA;
            nxt.phase           = 2'd0;
         end
      end else if (!is_cmd) begin
         // By default the segment advances to its next phase.
         nxt.phase = cur.phase + 2'd1;
         case (cur.seg)
            SEG_STARTA, SEG_STARTB: begin
               case (cur.phase)
                  2'd0: nxt.sda = 1'b1;
                  2'd1: begin
                     nxt.scl = 1'b1;
                     if (!sda_in) begin
                        res.done   = 1'b1;
                        res.status = STATUS_BUS_BUSY;
                        nxt.seg    = SEG_IDLE;
                        nxt.phase  = 2'd0;
                     end
                  end
                  2'd2: begin
                     nxt.sda = 1'b0;
                     if (sda_in) begin
                        res.done   = 1'b1;
                        res.status = STATUS_LINE_STUCK;
                        nxt.seg    = SEG_IDLE;
                        nxt.phase  = 2'd0;
                     end
                  end
                  default: begin
                     nxt.scl       = 1'b0;
                     nxt.bit_count = 4'd0;
                     nxt.phase     = 2'd0;
                     if (cur.seg == SEG_STARTA) begin
                        nxt.seg        = SEG_DEVW;
                        nxt.shift_byte = device_address;
                     end else begin
                        nxt.seg        = SEG_DEVR;
                        nxt.shift_byte = device_address + 8'd1;
                     end
                  end
               endcase
            end
            SEG_DEVW, SEG_REG, SEG_DATA, SEG_DEVR: begin
               case (cur.phase)
                  2'd0: nxt.scl = 1'b0;
                  2'd1: begin
                     nxt.sda        = cur.shift_byte[7];
                     nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
                  end
                  default: begin
                     nxt.scl   = 1'b1;
                     nxt.phase = 2'd0;
                     if (bc_inc >= 4'd8) begin
                        nxt.bit_count = 4'd0;
                        nxt.seg       = seg_type'(cur.seg + 4'd1);
                     end else begin
                        nxt.bit_count = bc_inc;
                     end
                  end
               endcase
            end
            SEG_ACKDEV, SEG_ACKREG, SEG_ACKDATA, SEG_ACKDEVR: begin
               case (cur.phase)
                  2'd0: nxt.scl = 1'b0;
                  2'd1: nxt.sda = 1'b1;
                  default: begin
                     nxt.scl   = 1'b1;
                     nxt.phase = 2'd0;
                     // The acks after the register address and data byte are ignored.
                     case (cur.seg)
                        SEG_ACKDEV: begin
                           if (sda_in) begin
                              nxt.seg = SEG_STOPABORT;
                           end else begin
                              nxt.seg        = SEG_REG;
                              nxt.shift_byte = cur.held_reg_addr;
                              nxt.bit_count  = 4'd0;
                           end
                        end
                        SEG_ACKREG: begin
                           if (cur.is_read) begin
                              nxt.seg = SEG_STOPMID;
                           end else begin
                              nxt.seg        = SEG_DATA;
                              nxt.shift_byte = cur.held_write_data;
                              nxt.bit_count  = 4'd0;
                           end
                        end
                        SEG_ACKDATA: nxt.seg = SEG_STOPEND;
                        default: begin
                           if (sda_in) begin
                              nxt.seg = SEG_STOPABORT;
                           end else if (cur.bytes_left == 8'd0) begin
                              nxt.seg = SEG_STOPEND;
                           end else begin
                              nxt.seg        = SEG_RX;
                              nxt.shift_byte = 8'd0;
                              nxt.bit_count  = 4'd0;
                           end
                        end
                     endcase
                  end
               endcase
            end
            SEG_STOPEND, SEG_STOPABORT, SEG_STOPMID: begin
               case (cur.phase)
                  2'd0: nxt.scl = 1'b0;
                  2'd1: nxt.sda = 1'b0;
                  2'd2: nxt.scl = 1'b1;
                  default: begin
                     nxt.sda   = 1'b1;
                     nxt.phase = 2'd0;
                     if (cur.seg == SEG_STOPMID) begin
                        nxt.seg = SEG_STARTB;
                     end else begin
                        res.done   = 1'b1;
                        res.status = (cur.seg == SEG_STOPABORT) ? STATUS_NO_ACK : STATUS_OK;
                        nxt.seg    = SEG_IDLE;
                     end
                  end
               endcase
            end
            SEG_RX: begin
               if (cur.phase == 2'd0) begin
                  nxt.scl = 1'b0;
                  nxt.sda = 1'b1;
               end else begin
                  nxt.scl        = 1'b1;
                  nxt.shift_byte = rx_shift;
                  nxt.phase      = 2'd0;
                  if (bc_inc >= 4'd8) begin
                     res.read_valid = 1'b1;
                     res.read_data  = rx_shift;
                     res.read_last  = (cur.bytes_left == 8'd1);
                     nxt.bit_count  = 4'd0;
                     nxt.seg        = SEG_MACK;
                  end else begin
                     nxt.bit_count = bc_inc;
                  end
               end
            end
            default: begin
               // Master ack phase: the last byte gets a no-ack.
               case (cur.phase)
                  2'd0: nxt.scl = 1'b0;
                  2'd1: nxt.sda = (cur.bytes_left <= 8'd1);
                  2'd2: nxt.scl = 1'b1;
                  default: begin
                     nxt.scl        = 1'b0;
                     nxt.bytes_left = bl_dec;
                     nxt.phase      = 2'd0;
                     if (bl_dec == 8'd0) begin
                        nxt.seg = SEG_STOPEND;
                     end else begin
                        nxt.seg        = SEG_RX;
                        nxt.shift_byte = 8'd0;
                        nxt.bit_count  = 4'd0;
                     end
                  end
               endcase
            end
         endcase
      end
      res.scl  = nxt.scl;
      res.sda  = nxt.sda;
      res.busy = (nxt.seg != SEG_IDLE);
   end

endmodule

`default_nettype wire

// ----- hdl/scm_rsp_reg.sv -----
// Result register of the SCCB register master with its output handshake.
// Depends on scm_pkg.
`default_nettype none

module scm_rsp_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  scm_pkg::result_type load_res,
   output logic                can_load,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // scl_out, sda_out, busy_res, done_res, status[1:0], read_data[7:0],
   // read_valid, zero fill
   output logic [15:0]         rsp_tdata,
   output logic                rsp_tlast   // read_last
);
   import scm_pkg::*;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_res_ff;

   // A new result may enter when the register is empty or is drained this cycle.
   assign can_load     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_res_ff <= load_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_res_ff.read_valid, rsp_res_ff.read_data,
                        rsp_res_ff.status, rsp_res_ff.done, rsp_res_ff.busy,
                        rsp_res_ff.sda, rsp_res_ff.scl};
   assign rsp_tlast  = rsp_res_ff.read_last;

endmodule

`default_nettype wire

// ----- hdl/sccb_register_master.sv -----
// Top level of the SCCB register master: controller state, device address
// register and result channel. Depends on scm_pkg, scm_step, scm_rsp_reg and the macros header.
`default_nettype none
`include "sccb_register_master_macros.svh"

// SCCB register master. Each transfer on the req_ channel moves the bus by one
// phase (a tick) or, while the controller is idle, latches a register write or
// register read command; the next ticks then run start, address bytes, data,
// acks and stop, with the sampled SDA level of each phase carried in sda_in.
// Every accepted item yields exactly one result on the rsp_ channel in the next
// cycle, holding the line levels, busy, done with its status, and any received
// byte. An item is accepted in every clock: the whole phase step is one pass of
// combinational logic between the state register and the result register, and
// the only throttle is the result register itself, which stalls req_tready while
// a result waits and rsp_tready is low. The user must write the device address
// register (csr_wen, csr_wdata) only while idle; the block does not enforce it.
module sccb_register_master (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [7:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // reg_addr[7:0], write_data[7:0], read_length[7:0], sda_in, zero fill
   input  logic [31:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // scl_out, sda_out, busy_res, done_res, status[1:0], read_data[7:0],
   // read_valid, zero fill
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast   // read_last
);
   import scm_pkg::*;

   logic [7:0] device_addr_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type step_res;
   logic       req_accept;
   logic       can_load;

   assign req_tready = can_load;
   assign req_accept = req_tvalid && can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_addr_ff <= DEVICE_ADDRESS_RESET;
      end else if (csr_wen) begin
         device_addr_ff <= csr_wdata;
      end
   end

   scm_step u_step (
      .cur            (state_ff),
      .operation      (req_tuser),
      .reg_addr       (req_tdata[7:0]),
      .write_data     (req_tdata[15:8]),
      .read_length    (req_tdata[23:16]),
      .sda_in         (req_tdata[24]),
      .device_address (device_addr_ff),
      .nxt            (state_in),
      .res            (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   scm_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept),
      .load_res   (step_res),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `SCM_ASSERT_NEXT(a_done_goes_idle, clock, reset,
      req_accept && step_res.done, state_ff.seg == SEG_IDLE)
   `SCM_ASSERT_NEXT(a_byte_then_mack, clock, reset,
      req_accept && step_res.read_valid, state_ff.seg == SEG_MACK)
   `SCM_ASSERT_NEXT(a_cmd_starts, clock, reset,
      req_accept && (state_ff.seg == SEG_IDLE) &&
         ((req_tuser == OP_WRITE) || (req_tuser == OP_READ)),
      (state_ff.seg == SEG_STARTA) && (state_ff.phase == 2'd0))
   `SCM_ASSERT(a_status_needs_done, clock, reset,
      (step_res.status != STATUS_OK) |-> step_res.done)
   `SCM_ASSERT(a_bit_count_range, clock, reset, state_ff.bit_count <= 4'd8)
   `SCM_ASSERT_NEXT(a_csr_written, clock, reset,
      csr_wen, device_addr_ff == $past(csr_wdata))

endmodule

`default_nettype wire

// ----- tb/sv/sccb_register_master_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sccb_register_master: a directed table, then random
// write and read transactions with faults, checked against a phase-level predictor.
// Depends on scm_pkg and the sccb_register_master RTL.

module sccb_register_master_test;
   import scm_pkg::*;

   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int QUIET_LIMIT = 1000;
   localparam int DIRECTED_ROWS = 20;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      status_type status;
      logic [7:0] rdata;
      logic       rvalid;
      logic       rlast;
   } phase_result_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [7:0]       raddr;
      logic [7:0]       wdat;
      logic [7:0]       rlen;
      logic             sda;
      logic             typed;
      phase_result_type want;
   } directed_row_type;

   typedef enum logic [2:0] {
      FAULT_NONE,
      FAULT_BUS_BUSY,
      FAULT_STUCK,
      FAULT_NACK,
      FAULT_NOISE
   } fault_kind_type;

   typedef enum logic [1:0] {
      RX_STREAM,
      RX_SPOTTY,
      RX_TRICKLE
   } stall_kind_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic [7:0]  csr_wdata = 8'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = 32'd0;
   logic [1:0]  req_tuser = OP_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;

   sccb_register_master u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Predicted controller state.
   seg_type    bus_seg = SEG_IDLE;
   logic [1:0] bus_phase = 2'd0;
   logic [3:0] bits_done = 4'd0;
   logic [7:0] shifter = 8'd0;
   logic [7:0] bytes_to_read = 8'd0;
   logic [7:0] latched_reg = 8'd0;
   logic [7:0] latched_data = 8'd0;
   logic       read_cmd = 1'b0;
   logic       scl_now = 1'b1;
   logic       sda_now = 1'b1;
   logic [7:0] target_addr = DEVICE_ADDRESS_RESET;

   phase_result_type pending_results[$];
   directed_row_type directed_rows[DIRECTED_ROWS];
   int unsigned      active_items = 0;
   int unsigned      mismatches = 0;
   int               burst_left = 0;
   int unsigned      quiet_cycles = 0;
   int unsigned      stall_tick = 0;
   stall_kind_type   stall_mode = RX_STREAM;

   function automatic void enter(input seg_type seg);
      bus_seg = seg;
      bus_phase = 2'd0;
   endfunction

   function automatic void load_byte(input seg_type seg, input logic [7:0] value);
      shifter = value;
      bits_done = 4'd0;
      enter(seg);
   endfunction

   function automatic phase_result_type bus_levels(input logic scl, input logic sda,
         input logic busy, input logic done, input status_type st);
      phase_result_type r;
      r = '0;
      r.scl = scl;
      r.sda = sda;
      r.busy = busy;
      r.done = done;
      r.status = st;
      return r;
   endfunction

   // Moves the predicted bus by one item and returns the result it should produce.
   function automatic phase_result_type advance_bus(input logic [1:0] op,
         input logic [7:0] raddr, input logic [7:0] wdat, input logic [7:0] rlen,
         input logic sda_in);
      phase_result_type r;
      seg_type          seg;
      logic             keep;
      logic             is_cmd;
      r = '0;
      seg = bus_seg;
      keep = 1'b1;
      is_cmd = (op == OP_WRITE) || (op == OP_READ);
      if (seg == SEG_IDLE) begin
         if (is_cmd) begin
            latched_reg = raddr;
            latched_data = wdat;
            bytes_to_read = rlen;
            read_cmd = (op == OP_READ);
            enter(SEG_STARTA);
         end
      end else if (!is_cmd) begin
         case (seg)
            SEG_STARTA, SEG_STARTB: begin
               case (bus_phase)
                  2'd0: sda_now = 1'b1;
                  2'd1: begin
                     scl_now = 1'b1;
                     if (!sda_in) begin
                        r.done = 1'b1;
                        r.status = STATUS_BUS_BUSY;
                        enter(SEG_IDLE);
                        keep = 1'b0;
                     end
                  end
                  2'd2: begin
                     sda_now = 1'b0;
                     if (sda_in) begin
                        r.done = 1'b1;
                        r.status = STATUS_LINE_STUCK;
                        enter(SEG_IDLE);
                        keep = 1'b0;
                     end
                  end
                  default: begin
                     scl_now = 1'b0;
                     if (seg == SEG_STARTA) load_byte(SEG_DEVW, target_addr);
                     else load_byte(SEG_DEVR, target_addr + 8'd1);
                     keep = 1'b0;
                  end
               endcase
            end
            SEG_DEVW, SEG_REG, SEG_DATA, SEG_DEVR: begin
               if (bus_phase == 2'd0) begin
                  scl_now = 1'b0;
               end else if (bus_phase == 2'd1) begin
                  sda_now = shifter[7];
                  shifter = {shifter[6:0], 1'b0};
               end else begin
                  scl_now = 1'b1;
                  bits_done = bits_done + 4'd1;
                  keep = 1'b0;
                  if (bits_done >= 4'd8) begin
                     bits_done = 4'd0;
                     enter(seg_type'(seg + 4'd1));
                  end else begin
                     bus_phase = 2'd0;
                  end
               end
            end
            SEG_ACKDEV, SEG_ACKREG, SEG_ACKDATA, SEG_ACKDEVR: begin
               if (bus_phase == 2'd0) begin
                  scl_now = 1'b0;
               end else if (bus_phase == 2'd1) begin
                  sda_now = 1'b1;
               end else begin
                  scl_now = 1'b1;
                  keep = 1'b0;
                  // A high SDA in the ack slot means nobody acknowledged.
                  if (seg == SEG_ACKDEV) begin
                     if (sda_in) enter(SEG_STOPABORT);
                     else load_byte(SEG_REG, latched_reg);
                  end else if (seg == SEG_ACKREG) begin
                     if (read_cmd) enter(SEG_STOPMID);
                     else load_byte(SEG_DATA, latched_data);
                  end else if (seg == SEG_ACKDATA) begin
                     enter(SEG_STOPEND);
                  end else if (sda_in) begin
                     enter(SEG_STOPABORT);
                  end else if (bytes_to_read == 8'd0) begin
                     enter(SEG_STOPEND);
                  end else begin
                     load_byte(SEG_RX, 8'd0);
                  end
               end
            end
            SEG_STOPEND, SEG_STOPABORT, SEG_STOPMID: begin
               case (bus_phase)
                  2'd0: scl_now = 1'b0;
                  2'd1: sda_now = 1'b0;
                  2'd2: scl_now = 1'b1;
                  default: begin
                     sda_now = 1'b1;
                     keep = 1'b0;
                     if (seg == SEG_STOPMID) begin
                        enter(SEG_STARTB);
                     end else begin
                        r.done = 1'b1;
                        r.status = (seg == SEG_STOPABORT) ? STATUS_NO_ACK : STATUS_OK;
                        enter(SEG_IDLE);
                     end
                  end
               endcase
            end
            SEG_RX: begin
               if (bus_phase == 2'd0) begin
                  scl_now = 1'b0;
                  sda_now = 1'b1;
               end else begin
                  scl_now = 1'b1;
                  shifter = {shifter[6:0], sda_in};
                  bits_done = bits_done + 4'd1;
                  keep = 1'b0;
                  if (bits_done >= 4'd8) begin
                     r.rvalid = 1'b1;
                     r.rdata = shifter;
                     r.rlast = (bytes_to_read == 8'd1);
                     bits_done = 4'd0;
                     enter(SEG_MACK);
                  end else begin
                     bus_phase = 2'd0;
                  end
               end
            end
            default: begin
               // Master ack slot: no-ack after the last byte.
               case (bus_phase)
                  2'd0: scl_now = 1'b0;
                  2'd1: sda_now = (bytes_to_read <= 8'd1);
                  2'd2: scl_now = 1'b1;
                  default: begin
                     scl_now = 1'b0;
                     if (bytes_to_read > 8'd0) bytes_to_read = bytes_to_read - 8'd1;
                     keep = 1'b0;
                     if (bytes_to_read == 8'd0) enter(SEG_STOPEND);
                     else load_byte(SEG_RX, 8'd0);
                  end
               endcase
            end
         endcase
         if (keep) bus_phase = bus_phase + 2'd1;
      end
      r.scl = scl_now;
      r.sda = sda_now;
      r.busy = (bus_seg != SEG_IDLE);
      return r;
   endfunction

   // Sends one item, predicts its result once the transfer happens, then maybe
   // drops valid for a gap between bursts.
   task automatic send_item(input logic [1:0] op, input logic [7:0] raddr,
         input logic [7:0] wdat, input logic [7:0] rlen, input logic sd,
         input logic typed, input phase_result_type want);
      phase_result_type predicted;
      int               gap;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {7'd0, sd, rlen, wdat, raddr};
      do @(posedge clock); while (!req_tready);
      active_items++;
      predicted = advance_bus(op, raddr, wdat, rlen, sd);
      pending_results.push_back(typed ? want : predicted);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
         burst_left = int'($urandom_range(0, 40));
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_target_addr(input logic [7:0] value);
      drain();
      repeat (2) @(posedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      target_addr = value;
   endtask

   // Ticks the bus until the transaction ends. SDA is chosen so that the start
   // checks and the device acks pass, unless the fault plan says otherwise.
   task automatic run_to_idle(input fault_kind_type fault, input logic on_restart);
      logic sd;
      logic at_fault;
      while (bus_seg != SEG_IDLE) begin
         sd = 1'($urandom_range(0, 1));
         at_fault = (on_restart == (bus_seg == SEG_STARTB || bus_seg == SEG_ACKDEVR));
         if (fault != FAULT_NOISE) begin
            case (bus_seg)
               SEG_STARTA, SEG_STARTB: begin
                  if (bus_phase == 2'd1) sd = !(at_fault && fault == FAULT_BUS_BUSY);
                  else if (bus_phase == 2'd2) sd = at_fault && fault == FAULT_STUCK;
               end
               SEG_ACKDEV, SEG_ACKDEVR: begin
                  if (bus_phase == 2'd2) sd = at_fault && fault == FAULT_NACK;
               end
               default: ;
            endcase
         end
         if ($urandom_range(0, 19) == 0) begin
            // A command while busy must be dropped without moving the bus.
            send_item(2'($urandom_range(1, 2)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), sd, 1'b0, '0);
         end else begin
            send_item(($urandom_range(0, 9) == 0) ? OP_SPARE : OP_TICK,
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), sd, 1'b0, '0);
         end
      end
   endtask

   initial begin
      int             row;
      int             txn;
      logic           reading;
      logic [7:0]     rlen;
      fault_kind_type fault;
      logic           on_restart;
      logic           long_read_done;
      long_read_done = 1'b0;

      // Reset levels, ignored commands, both start failures and the first
      // address bit of a write to the reset device address.
      directed_rows[0]  = '{OP_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1,
                            bus_levels(1'b1, 1'b1, 1'b0, 1'b0, STATUS_OK)};
      directed_rows[1]  = '{OP_SPARE, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1,
                            bus_levels(1'b1, 1'b1, 1'b0, 1'b0, STATUS_OK)};
      directed_rows[2]  = '{OP_WRITE, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1,
                            bus_levels(1'b1, 1'b1, 1'b1, 1'b0, STATUS_OK)};
      directed_rows[3]  = '{OP_READ,  8'h12, 8'h34, 8'h56, 1'b1, 1'b1,
                            bus_levels(1'b1, 1'b1, 1'b1, 1'b0, STATUS_OK)};
      directed_rows[4]  = '{OP_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1,
                            bus_levels(1'b1, 1'b1, 1'b1, 1'b0, STATUS_OK)};
      directed_rows[5]  = '{OP_SPARE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1,
                            bus_levels(1'b1, 1'b1, 1'b0, 1'b1, STATUS_BUS_BUSY)};
      directed_rows[6]  = '{OP_READ,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1,
                            bus_levels(1'b1, 1'b1, 1'b1, 1'b0, STATUS_OK)};
      directed_rows[7]  = '{OP_WRITE, 8'h55, 8'hAA, 8'h0F, 1'b0, 1'b1,
                            bus_levels(1'b1, 1'b1, 1'b1, 1'b0, STATUS_OK)};
      directed_rows[8]  = '{OP_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1'b1,
                            bus_levels(1'b1, 1'b1, 1'b1, 1'b0, STATUS_OK)};
      directed_rows[9]  = '{OP_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1'b1,
                            bus_levels(1'b1, 1'b1, 1'b1, 1'b0, STATUS_OK)};
      directed_rows[10] = '{OP_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1'b1,
                            bus_levels(1'b1, 1'b0, 1'b0, 1'b1, STATUS_LINE_STUCK)};
      directed_rows[11] = '{OP_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1,
                            bus_levels(1'b1, 1'b0, 1'b0, 1'b0, STATUS_OK)};
      directed_rows[12] = '{OP_WRITE, 8'h3C, 8'hC3, 8'h80, 1'b1, 1'b1,
                            bus_levels(1'b1, 1'b0, 1'b1, 1'b0, STATUS_OK)};
      directed_rows[13] = '{OP_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1'b1,
                            bus_levels(1'b1, 1'b1, 1'b1, 1'b0, STATUS_OK)};
      directed_rows[14] = '{OP_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1'b1,
                            bus_levels(1'b1, 1'b1, 1'b1, 1'b0, STATUS_OK)};
      directed_rows[15] = '{OP_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1,
                            bus_levels(1'b1, 1'b0, 1'b1, 1'b0, STATUS_OK)};
      directed_rows[16] = '{OP_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1,
                            bus_levels(1'b0, 1'b0, 1'b1, 1'b0, STATUS_OK)};
      directed_rows[17] = '{OP_TICK,  8'hA5, 8'h5A, 8'hFF, 1'b1, 1'b0, '0};
      directed_rows[18] = '{OP_SPARE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0};
      directed_rows[19] = '{OP_TICK,  8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, '0};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         send_item(directed_rows[row].op, directed_rows[row].raddr, directed_rows[row].wdat,
                   directed_rows[row].rlen, directed_rows[row].sda,
                   directed_rows[row].typed, directed_rows[row].want);
      end
      // The write left open by the table ends with no ack from the device.
      run_to_idle(FAULT_NACK, 1'b0);

      for (txn = 0; txn < 8 || active_items < 1400; txn++) begin
         if (txn == 0) write_target_addr(8'hFF);
         else if (txn == 2) write_target_addr(8'h00);
         else if (txn % 5 == 0) write_target_addr(8'($urandom_range(0, 255)));

         reading = 1'($urandom_range(0, 1));
         rlen = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
         case ($urandom_range(0, 11))
            7: fault = FAULT_BUS_BUSY;
            8: fault = FAULT_STUCK;
            9, 10: fault = FAULT_NACK;
            11: fault = FAULT_NOISE;
            default: fault = FAULT_NONE;
         endcase
         on_restart = 1'($urandom_range(0, 1));
         case (txn)
            0: begin
               // Zero-length read with the read address wrapping to zero.
               reading = 1'b1;
               rlen = 8'd0;
               fault = FAULT_NONE;
            end
            1: begin
               reading = 1'b0;
               fault = FAULT_NACK;
               on_restart = 1'b0;
            end
            2: begin
               reading = 1'b1;
               rlen = 8'd2;
               fault = FAULT_NACK;
               on_restart = 1'b1;
            end
            default: begin
               if (reading && !long_read_done && txn >= 3) begin
                  rlen = 8'($urandom_range(12, 24));
                  fault = FAULT_NONE;
                  long_read_done = 1'b1;
               end
            end
         endcase
         if (!reading) on_restart = 1'b0;

         send_item(reading ? OP_READ : OP_WRITE, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), rlen, 1'($urandom_range(0, 1)), 1'b0, '0);
         run_to_idle(fault, on_restart);
         repeat ($urandom_range(0, 2)) begin
            send_item(($urandom_range(0, 1) == 0) ? OP_SPARE : OP_TICK,
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("sccb_register_master_test: PASS");
      end else begin
         $display("sccb_register_master_test: FAIL");
      end
      $finish;
   end

   task automatic compare_field(input string name, input int unsigned want,
         input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Result side: stalls on its own pattern and checks each transfer in order.
   always @(posedge clock) begin : check_results
      phase_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with no item outstanding");
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            compare_field("scl_out", want.scl, rsp_tdata[0]);
            compare_field("sda_out", want.sda, rsp_tdata[1]);
            compare_field("busy_res", want.busy, rsp_tdata[2]);
            compare_field("done_res", want.done, rsp_tdata[3]);
            compare_field("status", want.status, rsp_tdata[5:4]);
            compare_field("read_data", want.rdata, rsp_tdata[13:6]);
            compare_field("read_valid", want.rvalid, rsp_tdata[14]);
            compare_field("read_last", want.rlast, rsp_tlast);
         end
      end
      stall_tick = stall_tick + 1;
      if (stall_tick % 150 == 0) begin
         case ($urandom_range(0, 2))
            0: stall_mode = RX_STREAM;
            1: stall_mode = RX_SPOTTY;
            default: stall_mode = RX_TRICKLE;
         endcase
      end
      case (stall_mode)
         RX_STREAM: rsp_tready <= 1'b1;
         RX_SPOTTY: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= (stall_tick % 5 == 0);
      endcase
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("sccb_register_master_test: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
